// ===== rtl/mrrt_pkg.sv =====
`timescale 1ns / 1ps

package mrrt_pkg;

  localparam logic [7:0] MAX_FRAME_LEN = 8'd62;
  localparam logic [7:0] NO_ROUTE      = 8'd255;
  localparam logic [7:0] BROADCAST     = 8'd255;
  localparam logic [7:0] SAT_COUNT     = 8'd255;

  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_V = 8'h56;

  localparam logic [3:0] LEN_BEACON   = 4'd5;
  localparam logic [3:0] LEN_RESPONSE = 4'd8;
  localparam logic [3:0] LEN_REQUEST  = 4'd9;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS   = 2'd0,
    CFG_BEACON_PERIOD = 2'd1,
    CFG_ALIVE_LIMIT   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       command;
    logic [7:0] frame_len;
    logic [7:0] rx_byte_0;
    logic [7:0] rx_byte_1;
    logic [7:0] rx_byte_2;
    logic [7:0] rx_byte_3;
    logic [7:0] rx_byte_4;
    logic [7:0] rx_byte_5;
    logic [7:0] rx_byte_6;
    logic [7:0] rx_byte_7;
    logic [7:0] rx_byte_8;
  } req_t;

  typedef struct packed {
    logic [7:0] dest_address;
    logic [3:0] tx_len;
    logic [7:0] tx_byte_0;
    logic [7:0] tx_byte_1;
    logic [7:0] tx_byte_2;
    logic [7:0] tx_byte_3;
    logic [7:0] tx_byte_4;
    logic [7:0] tx_byte_5;
    logic [7:0] tx_byte_6;
    logic [7:0] tx_byte_7;
    logic [7:0] tx_byte_8;
  } res_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] beacon_period;
    logic [7:0] alive_limit;
  } cfg_t;

  // stage request handed to the engine
  typedef struct packed {
    logic valid;
    req_t data;
  } stage_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } result_t;

endpackage

// ===== rtl/mrrt_chan_if.sv =====
`timescale 1ns / 1ps

interface mrrt_req_if;
  logic           valid;
  logic           ready;
  mrrt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrrt_res_if;
  logic           valid;
  logic           ready;
  mrrt_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mrrt_in_stage.sv =====
`timescale 1ns / 1ps

module mrrt_in_stage (
  input  logic                clk,
  input  logic                rst,
  mrrt_req_if.sink            req_in,
  input  logic                fire,
  output mrrt_pkg::stage_t    stage
);

  logic           valid;
  mrrt_pkg::req_t data;

  // take a new request when empty or when the held one moves on this cycle
  assign req_in.ready = !valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_in.valid && req_in.ready) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_in.valid && req_in.ready) begin
      data <= req_in.data;
    end
  end

  assign stage.valid = valid;
  assign stage.data  = data;

endmodule

// ===== rtl/mrrt_engine.sv =====
`timescale 1ns / 1ps

module mrrt_engine (
  input  logic              clk,
  input  logic              rst,
  input  mrrt_pkg::cfg_t    cfg,
  input  mrrt_pkg::stage_t  stage,
  input  logic              fire,
  output mrrt_pkg::result_t result
);

  logic [7:0] tick_phase, tick_phase_next;
  logic [7:0] silence_count, silence_count_next;
  logic [7:0] route_neighbor, route_neighbor_next;
  logic [7:0] route_hops, route_hops_next;

  mrrt_pkg::req_t r;
  logic           len_bad;
  logic           is_serv;
  logic           is_ret;
  logic [7:0]     sc_inc;

  assign r = stage.data;

  always_comb begin
    len_bad = (r.frame_len == 8'd0) || (r.frame_len > mrrt_pkg::MAX_FRAME_LEN);
    is_serv = (r.rx_byte_1 == mrrt_pkg::CH_S) && (r.rx_byte_2 == mrrt_pkg::CH_E) &&
              (r.rx_byte_3 == mrrt_pkg::CH_R) && (r.rx_byte_4 == mrrt_pkg::CH_V);
    is_ret  = (r.rx_byte_1 == mrrt_pkg::CH_R) && (r.rx_byte_2 == mrrt_pkg::CH_E) &&
              (r.rx_byte_3 == mrrt_pkg::CH_T);
    sc_inc  = (silence_count < mrrt_pkg::SAT_COUNT) ? silence_count + 8'd1 : silence_count;
  end

  always_comb begin
    tick_phase_next     = tick_phase;
    silence_count_next  = silence_count;
    route_neighbor_next = route_neighbor;
    route_hops_next     = route_hops;
    result              = '0;

    if (r.command == mrrt_pkg::CMD_TICK) begin
      if (tick_phase == 8'd0) begin
        silence_count_next = sc_inc;
        if (sc_inc > cfg.alive_limit) begin
          route_neighbor_next = mrrt_pkg::NO_ROUTE;
          route_hops_next     = mrrt_pkg::NO_ROUTE;
        end
        if (route_hops_next < mrrt_pkg::NO_ROUTE) begin
          result.valid             = 1'b1;
          result.data.dest_address = mrrt_pkg::BROADCAST;
          result.data.tx_len       = mrrt_pkg::LEN_BEACON;
          result.data.tx_byte_0    = cfg.own_address;
          result.data.tx_byte_1    = mrrt_pkg::CH_R;
          result.data.tx_byte_2    = mrrt_pkg::CH_E;
          result.data.tx_byte_3    = mrrt_pkg::CH_T;
          result.data.tx_byte_4    = route_hops_next + 8'd1;
        end
      end
      // 9-bit compare so a lowered period still wraps; period 0 behaves as 1
      if ({1'b0, tick_phase} + 9'd1 >= {1'b0, cfg.beacon_period}) begin
        tick_phase_next = 8'd0;
      end else begin
        tick_phase_next = tick_phase + 8'd1;
      end
    end else if (!len_bad) begin
      if (is_serv) begin
        silence_count_next  = 8'd0;
        route_neighbor_next = r.rx_byte_0;
        route_hops_next     = 8'd0;
      end else if (is_ret) begin
        if (r.rx_byte_0 == route_neighbor) begin
          silence_count_next = 8'd0;
        end
        if (r.rx_byte_4 < route_hops) begin
          route_neighbor_next = r.rx_byte_0;
          route_hops_next     = r.rx_byte_4;
          silence_count_next  = 8'd0;
        end
      end else begin
        result.valid          = 1'b1;
        result.data.tx_byte_0 = cfg.own_address;
        result.data.tx_byte_1 = r.rx_byte_1;
        result.data.tx_byte_2 = r.rx_byte_2;
        result.data.tx_byte_3 = r.rx_byte_3;
        result.data.tx_byte_4 = r.rx_byte_4;
        result.data.tx_byte_5 = r.rx_byte_5;
        result.data.tx_byte_6 = r.rx_byte_6;
        result.data.tx_byte_7 = r.rx_byte_7;
        if (r.rx_byte_0 == route_neighbor) begin
          result.data.dest_address = mrrt_pkg::BROADCAST;
          result.data.tx_len       = mrrt_pkg::LEN_RESPONSE;
        end else begin
          result.data.dest_address = route_neighbor;
          result.data.tx_len       = mrrt_pkg::LEN_REQUEST;
          result.data.tx_byte_8    = r.rx_byte_8;
        end
      end
    end

    if (!stage.valid) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase     <= 8'd0;
      silence_count  <= 8'd0;
      route_neighbor <= mrrt_pkg::NO_ROUTE;
      route_hops     <= mrrt_pkg::NO_ROUTE;
    end else if (fire) begin
      tick_phase     <= tick_phase_next;
      silence_count  <= silence_count_next;
      route_neighbor <= route_neighbor_next;
      route_hops     <= route_hops_next;
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable({tick_phase, silence_count, route_neighbor, route_hops}))
    else $error("route state changed without a request");

  a_beacon_has_route: assert property (@(posedge clk) disable iff (rst)
    fire && result.valid && (r.command == mrrt_pkg::CMD_TICK)
    |=> route_hops != mrrt_pkg::NO_ROUTE)
    else $error("beacon sent without a route");

  a_bad_len_drop: assert property (@(posedge clk) disable iff (rst)
    fire && (r.command == mrrt_pkg::CMD_FRAME) && len_bad
    |=> $stable({tick_phase, silence_count, route_neighbor, route_hops}))
    else $error("bad-length frame changed route state");

  a_bad_len_silent: assert property (@(posedge clk) disable iff (rst)
    stage.valid && (r.command == mrrt_pkg::CMD_FRAME) && len_bad |-> !result.valid)
    else $error("bad-length frame produced a result");

endmodule

// ===== rtl/mrrt_out_stage.sv =====
`timescale 1ns / 1ps

module mrrt_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  mrrt_pkg::result_t result,
  input  logic              fire,
  output logic              free,
  mrrt_res_if.source        res_out
);

  logic           valid;
  mrrt_pkg::res_t data;

  assign free = !valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire && result.valid) begin
      valid <= 1'b1;
    end else if (res_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.valid) begin
      data <= result.data;
    end
  end

  assign res_out.valid = valid;
  assign res_out.data  = data;

endmodule

// ===== rtl/mesh_relay_route_tracker.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                                         accepted when
// req_in    in   command, frame_len, rx_byte_0..rx_byte_8        valid && ready
// res_out   out  dest_address, tx_len, tx_byte_0..tx_byte_8      valid && ready
// cfg       in   cfg_index (0 addr, 1 period, 2 limit), cfg_wdata cfg_we
//
// One request per cycle sustained while the result register is free; a result is offered
// once its request has passed through the input register, then route logic into the result
// register.
// Ticks and dropped frames produce no result but still wait for a free result register.
// rst (synchronous) clears the stages and route state and loads register defaults.
// A stalled result only holds the input stage once that stage also fills.

module mesh_relay_route_tracker (
  input  logic                              clk,
  input  logic                              rst,
  mrrt_req_if.sink                          req_in,
  mrrt_res_if.source                        res_out,
  input  logic                              cfg_we,
  input  logic [mrrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_wdata
);

  mrrt_pkg::cfg_t    cfg;
  mrrt_pkg::stage_t  stage;
  mrrt_pkg::result_t result;
  logic              out_free;
  logic              fire;

  assign fire = stage.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address   <= 8'd1;
      cfg.beacon_period <= 8'd10;
      cfg.alive_limit   <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        mrrt_pkg::CFG_OWN_ADDRESS:   cfg.own_address   <= cfg_wdata;
        mrrt_pkg::CFG_BEACON_PERIOD: cfg.beacon_period <= cfg_wdata;
        mrrt_pkg::CFG_ALIVE_LIMIT:   cfg.alive_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mrrt_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .req_in (req_in),
    .fire   (fire),
    .stage  (stage)
  );

  mrrt_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stage  (stage),
    .fire   (fire),
    .result (result)
  );

  mrrt_out_stage u_out_stage (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .fire    (fire),
    .free    (out_free),
    .res_out (res_out)
  );

endmodule

// ===== test/relay_frame_checker.sv =====
`timescale 1ns / 1ps

module relay_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  mrrt_req_if                            req_mon,
  mrrt_res_if                            res_mon,
  input  logic                           cfg_we,
  input  logic [mrrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  output int                             fail_count,
  output int                             frames_due
);

  import mrrt_pkg::*;

  logic [7:0] own_addr;
  logic [7:0] period;
  logic [7:0] alive_lim;

  logic [7:0] phase;
  logic [7:0] silence;
  logic [7:0] next_hop;
  logic [7:0] hops;

  res_t tx_due_q[$];

  // advance the route state by one request; returns 1 when a frame goes out
  function automatic bit route_step(input req_t r, output res_t tx);
    bit made;
    made = 1'b0;
    tx = '0;
    if (r.command == CMD_TICK) begin
      if (phase == 8'd0) begin
        if (silence != SAT_COUNT) silence++;
        if (silence > alive_lim) begin
          next_hop = NO_ROUTE;
          hops = NO_ROUTE;
        end
        if (hops != NO_ROUTE) begin
          tx.dest_address = BROADCAST;
          tx.tx_len = LEN_BEACON;
          tx.tx_byte_0 = own_addr;
          tx.tx_byte_1 = CH_R;
          tx.tx_byte_2 = CH_E;
          tx.tx_byte_3 = CH_T;
          tx.tx_byte_4 = hops + 8'd1;
          made = 1'b1;
        end
      end
      // period 0 behaves like 1; a lowered period wraps on the next tick
      if ({1'b0, phase} + 9'd1 >= {1'b0, period}) phase = 8'd0;
      else phase = phase + 8'd1;
      return made;
    end
    if (r.frame_len == 8'd0 || r.frame_len > MAX_FRAME_LEN) return 1'b0;
    if (r.rx_byte_1 == CH_S && r.rx_byte_2 == CH_E && r.rx_byte_3 == CH_R &&
        r.rx_byte_4 == CH_V) begin
      silence = 8'd0;
      next_hop = r.rx_byte_0;
      hops = 8'd0;
      return 1'b0;
    end
    if (r.rx_byte_1 == CH_R && r.rx_byte_2 == CH_E && r.rx_byte_3 == CH_T) begin
      if (r.rx_byte_0 == next_hop) silence = 8'd0;
      if (r.rx_byte_4 < hops) begin
        next_hop = r.rx_byte_0;
        hops = r.rx_byte_4;
        silence = 8'd0;
      end
      return 1'b0;
    end
    tx.tx_byte_0 = own_addr;
    tx.tx_byte_1 = r.rx_byte_1;
    tx.tx_byte_2 = r.rx_byte_2;
    tx.tx_byte_3 = r.rx_byte_3;
    tx.tx_byte_4 = r.rx_byte_4;
    tx.tx_byte_5 = r.rx_byte_5;
    tx.tx_byte_6 = r.rx_byte_6;
    tx.tx_byte_7 = r.rx_byte_7;
    if (r.rx_byte_0 == next_hop) begin
      tx.dest_address = BROADCAST;
      tx.tx_len = LEN_RESPONSE;
    end else begin
      tx.dest_address = next_hop;
      tx.tx_len = LEN_REQUEST;
      tx.tx_byte_8 = r.rx_byte_8;
    end
    return 1'b1;
  endfunction

  task automatic diff_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t tx;
    res_t want;
    if (rst) begin
      own_addr = 8'd1;
      period = 8'd10;
      alive_lim = 8'd3;
      phase = 8'd0;
      silence = 8'd0;
      next_hop = NO_ROUTE;
      hops = NO_ROUTE;
      tx_due_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS:   own_addr = cfg_wdata;
          CFG_BEACON_PERIOD: period = cfg_wdata;
          CFG_ALIVE_LIMIT:   alive_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        if (route_step(req_mon.data, tx)) tx_due_q.push_back(tx);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (tx_due_q.size() == 0) begin
          $error("unexpected frame to %0d, len %0d", res_mon.data.dest_address,
                 res_mon.data.tx_len);
          fail_count++;
        end else begin
          want = tx_due_q.pop_front();
          diff_field("dest_address", want.dest_address, res_mon.data.dest_address);
          diff_field("tx_len", 8'(want.tx_len), 8'(res_mon.data.tx_len));
          diff_field("tx_byte_0", want.tx_byte_0, res_mon.data.tx_byte_0);
          diff_field("tx_byte_1", want.tx_byte_1, res_mon.data.tx_byte_1);
          diff_field("tx_byte_2", want.tx_byte_2, res_mon.data.tx_byte_2);
          diff_field("tx_byte_3", want.tx_byte_3, res_mon.data.tx_byte_3);
          diff_field("tx_byte_4", want.tx_byte_4, res_mon.data.tx_byte_4);
          diff_field("tx_byte_5", want.tx_byte_5, res_mon.data.tx_byte_5);
          diff_field("tx_byte_6", want.tx_byte_6, res_mon.data.tx_byte_6);
          diff_field("tx_byte_7", want.tx_byte_7, res_mon.data.tx_byte_7);
          diff_field("tx_byte_8", want.tx_byte_8, res_mon.data.tx_byte_8);
        end
      end
    end
    frames_due = tx_due_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import mrrt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int REQ_W = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  mrrt_req_if req_ch ();
  mrrt_res_if res_ch ();

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  int fail_count;
  int frames_due;
  int idle_cycles;
  int stall_left;
  bit calm;
  logic [7:0] peers [4];

  mesh_relay_route_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req_ch),
    .res_out   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  relay_frame_checker frame_watch (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .frames_due (frames_due)
  );

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    int pick;
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (calm) begin
      res_ch.ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        res_ch.ready <= 1'b1;
      end else if (pick < 96) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL mesh_relay_route_tracker");
        $finish;
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t frame_of(input logic [7:0] len, src, t1, t2, t3, t4, fill);
    req_t r;
    r.command = CMD_FRAME;
    r.frame_len = len;
    r.rx_byte_0 = src;
    r.rx_byte_1 = t1;
    r.rx_byte_2 = t2;
    r.rx_byte_3 = t3;
    r.rx_byte_4 = t4;
    r.rx_byte_5 = fill;
    r.rx_byte_6 = fill;
    r.rx_byte_7 = fill;
    r.rx_byte_8 = fill;
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r = REQ_W'({$urandom(), $urandom(), $urandom()});
    r.command = CMD_TICK;
    return r;
  endfunction

  function automatic logic [7:0] some_peer();
    if ($urandom_range(0, 4) == 0) return 8'($urandom());
    return peers[$urandom_range(0, 3)];
  endfunction

  function automatic req_t random_req();
    req_t r;
    int pick;
    r = REQ_W'({$urandom(), $urandom(), $urandom()});
    r.command = CMD_FRAME;
    r.frame_len = 8'($urandom_range(1, MAX_FRAME_LEN));
    r.rx_byte_0 = some_peer();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.command = CMD_TICK;
    end else if (pick < 48) begin
      r.rx_byte_1 = CH_S;
      r.rx_byte_2 = CH_E;
      r.rx_byte_3 = CH_R;
      r.rx_byte_4 = CH_V;
    end else if (pick < 62) begin
      r.rx_byte_1 = CH_R;
      r.rx_byte_2 = CH_E;
      r.rx_byte_3 = CH_T;
      if ($urandom_range(0, 3) != 0) r.rx_byte_4 = 8'($urandom_range(0, 5));
    end else if (pick < 67) begin
      r.frame_len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(63, 255));
      if ($urandom_range(0, 1)) begin
        r.rx_byte_1 = CH_S;
        r.rx_byte_2 = CH_E;
        r.rx_byte_3 = CH_R;
        r.rx_byte_4 = CH_V;
      end
    end else if (pick < 75) begin
      // tag almost matches
      if ($urandom_range(0, 1)) begin
        r.rx_byte_1 = CH_S;
        r.rx_byte_2 = CH_E;
        r.rx_byte_3 = CH_R;
      end else begin
        r.rx_byte_1 = CH_R;
        r.rx_byte_2 = CH_E;
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (frames_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ticks with no frame may still be in the pipe after the last frame
  task automatic set_config(input logic [7:0] own, per, lim);
    hold_until_drained();
    repeat (6) @(negedge clk);
    write_reg(CFG_OWN_ADDRESS, own);
    write_reg(CFG_BEACON_PERIOD, per);
    write_reg(CFG_ALIVE_LIMIT, lim);
    foreach (peers[i]) peers[i] = 8'($urandom());
    if ($urandom_range(0, 1)) peers[3] = BROADCAST;
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 79) == 0) hold_until_drained();
      send_req(random_req());
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = 8'd0;
    calm = 1'b0;
    stall_left = 0;
    foreach (peers[i]) peers[i] = 8'd16 * 8'(i + 1);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default registers, no route yet
    send_req(tick_req());
    send_req(frame_of(8'd9, 8'h07, 8'h48, CH_E, 8'h4C, 8'h4F, 8'h3C));
    send_req(frame_of(8'd9, BROADCAST, 8'h48, CH_E, 8'h4C, 8'h4F, 8'hC3));
    send_req(frame_of(8'd0, 8'h20, CH_S, CH_E, CH_R, CH_V, 8'h00));
    send_req(frame_of(8'd63, 8'h20, CH_S, CH_E, CH_R, CH_V, 8'h00));
    send_req(frame_of(8'd255, 8'h21, 8'h41, 8'h42, 8'h43, 8'h44, 8'h00));
    send_req(frame_of(MAX_FRAME_LEN, 8'h20, CH_S, CH_E, CH_R, CH_V, 8'hFF));
    send_req(frame_of(8'd1, 8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(frame_of(MAX_FRAME_LEN, 8'h33, 8'h51, 8'h52, 8'h53, 8'h54, 8'hA7));
    send_req(frame_of(8'd5, 8'h40, CH_R, CH_E, CH_T, 8'd0, 8'h00));
    send_req(frame_of(8'd5, 8'h20, CH_R, CH_E, CH_T, 8'd9, 8'h00));
    repeat (10) send_req(tick_req());
    send_req(frame_of(8'd8, 8'h44, CH_S, CH_E, CH_R, 8'h58, 8'h5A));
    send_req(frame_of(8'd8, 8'h20, CH_R, CH_E, 8'h58, CH_T, 8'h5A));
    send_req(frame_of(8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    set_config(8'hFF, 8'd1, 8'd0);
    run_random(40);

    set_config(8'h00, 8'd0, 8'd2);
    run_random(40);

    // route held for over 255 checks: silence count must stick at its ceiling
    set_config(8'h5A, 8'd1, 8'd255);
    send_req(frame_of(8'd5, 8'h66, CH_S, CH_E, CH_R, CH_V, 8'h00));
    repeat (280) send_req(tick_req());
    set_config(8'h5A, 8'd1, 8'd100);
    repeat (3) send_req(tick_req());

    // shrink the period while the phase sits far past it
    set_config(8'hA5, 8'd200, 8'd3);
    send_req(frame_of(8'd5, 8'h71, CH_S, CH_E, CH_R, CH_V, 8'h00));
    repeat (60) send_req(tick_req());
    set_config(8'hA5, 8'd5, 8'd3);
    run_random(40);

    set_config(8'h00, 8'd255, 8'd255);
    run_random(40);

    set_config(8'($urandom()), 8'($urandom_range(1, 12)), 8'($urandom_range(0, 6)));
    run_random(40);
    calm = 1'b1;
    set_config(8'($urandom()), 8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
    run_random(40);
    calm = 1'b0;
    set_config(8'($urandom()), 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
    run_random(40);

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS mesh_relay_route_tracker");
    end else begin
      $display("FAIL mesh_relay_route_tracker");
    end
    $finish;
  end

endmodule
